[design/fpsf_pkg.sv]
// Shared constants, types and codes for the five-point stencil filter.
// Depends on nothing; the top level takes names from here by scope.
package fpsf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int CNT_BITS    = COL_BITS + 1;
    localparam int ROW_BITS    = 16;
    localparam int FW_BITS     = 11;
    localparam int CFG_BITS    = 16;
    localparam int SUM_BITS    = SAMPLE_BITS + 3;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS  = Q_PTR_BITS + 1;

    typedef logic        [COL_BITS-1:0]    col_t;
    typedef logic        [CNT_BITS-1:0]    cnt_t;
    typedef logic        [ROW_BITS-1:0]    row_t;
    typedef logic        [FW_BITS-1:0]     fw_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic        [Q_PTR_BITS-1:0]  qptr_t;
    typedef logic        [Q_CNT_BITS-1:0]  qcnt_t;

    localparam fw_t  FRAME_WIDTH_RST  = fw_t'(1024);
    localparam row_t FRAME_HEIGHT_RST = row_t'(1024);

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_DRAIN  = 1'b1
    } cmd_t;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic    eof;
        sample_t filtered;
    } q_entry_t;

endpackage

[design/five_point_stencil_filter.sv]
// Top level of the five-point stencil filter: frame counters, line buffers
// and output queue. Depends on fpsf_pkg and fpsf_ram.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+--------------------------------
//  s_*       | in        | s_tvalid / s_tready        | tdata: sample; tuser: cmd
//  m_*       | out       | m_tvalid / m_tready        | tdata: filtered; tlast: end_of_frame
//  cfg_*     | in        | cfg_we (no wait)           | cfg_index, cfg_data
//
//  One beat per cycle is taken in steady state. The accept cycle reads the line
//  buffers; the next cycle adds the five taps, writes back and, for a beat that
//  yields a result, pushes it into a four-entry output queue that drives m_*.
//  s_tready drops only when the queue could not hold the results still in flight.
//  Reset (rst_n low, asynchronous) clears counters, queue and flags; the line
//  buffers hold garbage until the frame writes them. No clearing pass is needed.
module five_point_stencil_filter (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tuser,   // [0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] filtered
    output logic        m_tlast,   // end_of_frame
    // configuration writes
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Per-item control carried from the read cycle to the compute cycle.
    typedef struct packed {
        logic                valid;
        logic                wr;        // sample item: writes both line buffers
        logic                emit;      // produces a result
        logic                north_en;
        logic                west_en;
        logic                east_en;
        logic                eof;
        logic                hit_c;     // center/north entry written last cycle
        logic                hit_e;     // east entry written last cycle
        fpsf_pkg::col_t      col;
        fpsf_pkg::sample_t   sample;
        fpsf_pkg::sample_t   fwd_sample;
    } s2_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    fpsf_pkg::fw_t  frame_width_reg;
    fpsf_pkg::row_t frame_height_reg;
    fpsf_pkg::cnt_t eff_w;
    fpsf_pkg::row_t eff_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= fpsf_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= fpsf_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (fpsf_pkg::cfg_idx_t'(cfg_index))
                fpsf_pkg::CFG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[fpsf_pkg::FW_BITS-1:0];
                fpsf_pkg::CFG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data;
            endcase
        end
    end

    // Clamp width to 1..MAX_WIDTH and height to at least one row.
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_w = fpsf_pkg::cnt_t'(1);
        end
        else if (32'(frame_width_reg) > 32'(fpsf_pkg::MAX_WIDTH))
        begin
            eff_w = fpsf_pkg::cnt_t'(fpsf_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_w = fpsf_pkg::cnt_t'(frame_width_reg);
        end
        eff_h = (frame_height_reg == '0) ? fpsf_pkg::row_t'(1) : frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Frame counters and read-cycle decode
    // ------------------------------------------------------------------
    fpsf_pkg::col_t in_col_reg,     in_col_next;
    fpsf_pkg::row_t in_row_reg,     in_row_next;
    fpsf_pkg::cnt_t drain_col_reg,  drain_col_next;
    logic           frame_done_reg, frame_done_next;

    s2_t            s2_reg, s2_next;
    logic           fire;
    logic           is_drain;
    logic           take;
    fpsf_pkg::row_t row_cur;
    fpsf_pkg::col_t col_cur;
    fpsf_pkg::col_t rd_col;
    fpsf_pkg::col_t east_col;
    fpsf_pkg::cnt_t rd_cnt_inc;
    logic           last_col;
    logic           s2_push;
    fpsf_pkg::qcnt_t q_cnt_reg;

    assign fire     = s_tvalid && s_tready;
    assign is_drain = (fpsf_pkg::cmd_t'(s_tuser) == fpsf_pkg::CMD_DRAIN);
    assign s2_push  = s2_reg.valid && s2_reg.emit;

    // Hold input while the queue could overflow with what is already in flight.
    assign s_tready = ({1'b0, q_cnt_reg} + {{fpsf_pkg::Q_CNT_BITS{1'b0}}, s2_push})
                      <= (fpsf_pkg::Q_CNT_BITS + 1)'(fpsf_pkg::Q_DEPTH - 1);

    always_comb
    begin
        // a finished frame restarts at the origin on the next sample
        row_cur    = frame_done_reg ? '0 : in_row_reg;
        col_cur    = frame_done_reg ? '0 : in_col_reg;
        rd_col     = is_drain ? fpsf_pkg::col_t'(drain_col_reg) : col_cur;
        east_col   = rd_col + fpsf_pkg::col_t'(1);
        rd_cnt_inc = fpsf_pkg::cnt_t'(rd_col) + fpsf_pkg::cnt_t'(1);
        last_col   = (rd_cnt_inc >= eff_w);
        take       = is_drain ? (!frame_done_reg && (in_row_reg >= eff_h))
                              : (row_cur < eff_h);

        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        drain_col_next  = drain_col_reg;
        frame_done_next = frame_done_reg;

        s2_next            = s2_reg;
        s2_next.valid      = fire && take;
        s2_next.wr         = !is_drain;
        s2_next.emit       = is_drain || (row_cur != '0);
        s2_next.north_en   = is_drain ? (eff_h > fpsf_pkg::row_t'(1))
                                      : (row_cur > fpsf_pkg::row_t'(1));
        s2_next.west_en    = (rd_col != '0);
        s2_next.east_en    = !last_col;
        s2_next.eof        = is_drain && last_col;
        s2_next.col        = rd_col;
        s2_next.sample     = s_tdata;
        s2_next.fwd_sample = s2_reg.sample;
        // forward over the write-back of the preceding item
        s2_next.hit_c      = s2_reg.valid && s2_reg.wr && (rd_col == s2_reg.col);
        s2_next.hit_e      = s2_reg.valid && s2_reg.wr && (east_col == s2_reg.col);

        if (cfg_we)
        begin
            in_col_next     = '0;
            in_row_next     = '0;
            drain_col_next  = '0;
            frame_done_next = 1'b0;
        end
        else if (fire)
        begin
            if (is_drain)
            begin
                if (take)
                begin
                    drain_col_next  = rd_cnt_inc;
                    frame_done_next = last_col;
                end
            end
            else
            begin
                if (frame_done_reg)
                begin
                    drain_col_next  = '0;
                    frame_done_next = 1'b0;
                end
                if (take)
                begin
                    in_col_next = last_col ? '0 : east_col;
                    in_row_next = last_col ? row_cur + fpsf_pkg::row_t'(1) : row_cur;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            drain_col_reg  <= '0;
            frame_done_reg <= 1'b0;
            s2_reg         <= '0;
        end
        else
        begin
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            drain_col_reg  <= drain_col_next;
            frame_done_reg <= frame_done_next;
            s2_reg         <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffers: row_above, and row_middle kept twice for two read ports
    // ------------------------------------------------------------------
    fpsf_pkg::sample_t above_rd, mid_c_rd, mid_e_rd;
    fpsf_pkg::sample_t ctr, north, south, west, east;
    logic              mem_wr;
    logic              mem_rd;

    assign mem_wr = s2_reg.valid && s2_reg.wr;
    assign mem_rd = fire && take;

    fpsf_ram #(
        .WIDTH (fpsf_pkg::SAMPLE_BITS),
        .DEPTH (fpsf_pkg::MAX_WIDTH)
    ) u_row_above (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (s2_reg.col),
        .wr_data (ctr),
        .rd_en   (mem_rd),
        .rd_addr (rd_col),
        .rd_data (above_rd)
    );

    fpsf_ram #(
        .WIDTH (fpsf_pkg::SAMPLE_BITS),
        .DEPTH (fpsf_pkg::MAX_WIDTH)
    ) u_row_middle_c (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (s2_reg.col),
        .wr_data (s2_reg.sample),
        .rd_en   (mem_rd),
        .rd_addr (rd_col),
        .rd_data (mid_c_rd)
    );

    fpsf_ram #(
        .WIDTH (fpsf_pkg::SAMPLE_BITS),
        .DEPTH (fpsf_pkg::MAX_WIDTH)
    ) u_row_middle_e (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (s2_reg.col),
        .wr_data (s2_reg.sample),
        .rd_en   (mem_rd),
        .rd_addr (east_col),
        .rd_data (mid_e_rd)
    );

    // ------------------------------------------------------------------
    // Compute cycle: five-tap sum, floor shift by three, write back
    // ------------------------------------------------------------------
    fpsf_pkg::sample_t held_west_reg;
    fpsf_pkg::sum_t    sum;
    fpsf_pkg::sample_t filtered;

    always_comb
    begin
        // held_west_reg is the previous center, which is also what the
        // previous item wrote to row_above
        ctr   = s2_reg.hit_c ? s2_reg.fwd_sample : mid_c_rd;
        north = !s2_reg.north_en ? '0 : (s2_reg.hit_c ? held_west_reg : above_rd);
        east  = !s2_reg.east_en  ? '0 : (s2_reg.hit_e ? s2_reg.fwd_sample : mid_e_rd);
        west  = s2_reg.west_en ? held_west_reg : '0;
        south = s2_reg.wr ? s2_reg.sample : '0;
        sum   = (fpsf_pkg::sum_t'(ctr) <<< 2) + fpsf_pkg::sum_t'(north)
              + fpsf_pkg::sum_t'(south) + fpsf_pkg::sum_t'(west)
              + fpsf_pkg::sum_t'(east);
        filtered = sum[fpsf_pkg::SUM_BITS-1:3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_west_reg <= '0;
        end
        else if (cfg_we)
        begin
            held_west_reg <= '0;
        end
        else if (s2_reg.valid)
        begin
            held_west_reg <= ctr;
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    fpsf_pkg::q_entry_t q_reg [fpsf_pkg::Q_DEPTH];
    fpsf_pkg::qptr_t    q_head_reg, q_tail_reg;
    fpsf_pkg::qcnt_t    q_cnt_next;
    logic               q_pop;

    assign m_tvalid = (q_cnt_reg != '0);
    assign q_pop    = m_tvalid && m_tready;
    assign m_tdata  = q_reg[q_head_reg].filtered;
    assign m_tlast  = q_reg[q_head_reg].eof;

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        case ({s2_push, q_pop})
            2'b10:   q_cnt_next = q_cnt_reg + fpsf_pkg::qcnt_t'(1);
            2'b01:   q_cnt_next = q_cnt_reg - fpsf_pkg::qcnt_t'(1);
            default: q_cnt_next = q_cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s2_push)
        begin
            q_reg[q_tail_reg] <= '{eof: s2_reg.eof, filtered: filtered};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_head_reg <= '0;
            q_tail_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (s2_push)
            begin
                q_tail_reg <= q_tail_reg + fpsf_pkg::qptr_t'(1);
            end
            if (q_pop)
            begin
                q_head_reg <= q_head_reg + fpsf_pkg::qptr_t'(1);
            end
            q_cnt_reg <= q_cnt_next;
        end
    end

`ifndef ASSERT_OFF
    // a result never arrives at a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_push |-> (q_cnt_reg != fpsf_pkg::qcnt_t'(fpsf_pkg::Q_DEPTH)))
        else $error("output queue overflow");

    // the input column stays inside the row
    assert property (@(posedge clk) disable iff (!rst_n)
        fpsf_pkg::cnt_t'(in_col_reg) < eff_w)
        else $error("input column beyond frame width");

    // draining never runs past the row end
    assert property (@(posedge clk) disable iff (!rst_n)
        drain_col_reg <= eff_w)
        else $error("drain column beyond frame width");

    // a frame is only done once every row has come in
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_done_reg |-> (in_row_reg >= eff_h))
        else $error("frame done before last row");

    // forwarding only ever follows an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_reg.valid && (s2_reg.hit_c || s2_reg.hit_e)) |-> $past(fire))
        else $error("forward hit without a preceding beat");
`endif

endmodule

[design/fpsf_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Self-contained; read during a write to the same entry returns the old data.
module fpsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
